@@ rtl/hsfr_pkg.sv @@
// Package for the humidity sensor frame reader: word types, codes and reset values.
package hsfr_pkg;

  localparam int unsigned FrameLen    = 5;
  localparam int unsigned HeldLen     = 4;
  localparam logic [5:0]  EdgeSat     = 6'd42;
  localparam logic [5:0]  FirstBitEdge = 6'd2;
  localparam int unsigned CfgAddrW    = 4;
  localparam int unsigned CfgDataW    = 32;

  localparam logic [15:0] IdleTicksRst  = 16'd250;
  localparam logic [15:0] StartTicksRst = 16'd3;
  localparam logic [15:0] ReadTicksRst  = 16'd2;
  localparam logic [15:0] OneBitGapRst  = 16'd90;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_READ  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    REG_IDLE_TICKS  = 2'd0,
    REG_START_TICKS = 2'd1,
    REG_READ_TICKS  = 2'd2,
    REG_ONE_BIT_GAP = 2'd3
  } reg_idx_e;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_EDGE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        cmd;
    logic [15:0] edge_time;
  } in_word_t;

  typedef struct packed {
    logic       drive_low;
    logic       capture_on;
    logic       done_res;
    logic       status;
    logic [7:0] humid_int;
    logic [7:0] humid_frac;
    logic [7:0] temp_int;
    logic [7:0] temp_frac;
  } out_word_t;

endpackage

@@ rtl/humidity_sensor_frame_reader_core.sv @@
// Humidity sensor frame reader: tick sequencer, edge decoder and result register.
//
// Each accepted word is either a time tick (cmd 0) or a captured line edge
// (cmd 1). A word is folded into the sequencer and frame state in the cycle it
// is accepted, and its result word appears in the output register on the next
// cycle, so the block takes one word per clock unless the output stalls. The
// output register decouples the sides: a new word is taken whenever the output
// register is empty or is being drained in the same cycle. Ticks count down idle,
// start and read phases; the line is driven low from the first tick counted in
// the start phase, and edges 2..41
// of a read window shift one bit each (1 when the 16-bit wrapped gap since the
// previous edge exceeds one_bit_gap) into a 5-byte frame. The tick that closes
// the window flags done_res and, for a full frame with a good 8-bit sum,
// latches the four data bytes and reports success. Tick counts written over
// the APB port take effect at the next countdown load; one_bit_gap applies
// from the next edge.
module humidity_sensor_frame_reader_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  hsfr_pkg::in_word_t                   in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output hsfr_pkg::out_word_t                  out_word_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hsfr_pkg::CfgAddrW-1:0]        paddr,
  input  logic [hsfr_pkg::CfgDataW-1:0]        pwdata,
  output logic [hsfr_pkg::CfgDataW-1:0]        prdata,
  output logic                                 pready
);

  // config registers
  logic [15:0] idle_ticks_q, start_ticks_q, read_ticks_q, one_bit_gap_q;
  logic        cfg_wr;
  hsfr_pkg::reg_idx_e cfg_idx;

  // sequencer and frame state
  hsfr_pkg::phase_e phase_q, phase_d;
  logic [15:0] tick_left_q, tick_left_d;
  logic [5:0]  edge_count_q, edge_count_d;
  logic [15:0] last_edge_q, last_edge_d;
  logic [2:0]  bit_in_byte_q, bit_in_byte_d;
  logic [2:0]  byte_index_q, byte_index_d;
  logic [7:0]  frame_q [hsfr_pkg::FrameLen];
  logic [7:0]  frame_d [hsfr_pkg::FrameLen];
  logic        frame_full_q, frame_full_d;
  logic        line_low_q, line_low_d;
  logic        status_q, status_d;
  logic [7:0]  held_q [hsfr_pkg::HeldLen];
  logic [7:0]  held_d [hsfr_pkg::HeldLen];
  logic        done;

  // output register
  logic                out_valid_q;
  hsfr_pkg::out_word_t out_word_q, out_word_d;

  logic        in_take;
  logic [15:0] tl_dec, gap;
  logic [7:0]  cur_byte, sum8;
  logic        shift_en;

  // ---------------- handshake ----------------
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_take     = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // ---------------- APB ----------------
  assign pready  = 1'b1;
  assign cfg_idx = hsfr_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    unique case (cfg_idx)
      hsfr_pkg::REG_IDLE_TICKS:  prdata = {16'd0, idle_ticks_q};
      hsfr_pkg::REG_START_TICKS: prdata = {16'd0, start_ticks_q};
      hsfr_pkg::REG_READ_TICKS:  prdata = {16'd0, read_ticks_q};
      default:                   prdata = {16'd0, one_bit_gap_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_ticks_q  <= hsfr_pkg::IdleTicksRst;
      start_ticks_q <= hsfr_pkg::StartTicksRst;
      read_ticks_q  <= hsfr_pkg::ReadTicksRst;
      one_bit_gap_q <= hsfr_pkg::OneBitGapRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        hsfr_pkg::REG_IDLE_TICKS:  idle_ticks_q  <= pwdata[15:0];
        hsfr_pkg::REG_START_TICKS: start_ticks_q <= pwdata[15:0];
        hsfr_pkg::REG_READ_TICKS:  read_ticks_q  <= pwdata[15:0];
        default:                   one_bit_gap_q <= pwdata[15:0];
      endcase
    end
  end

  // ---------------- next state ----------------
  // frame byte under the write pointer (guarded by byte_index < FrameLen)
  always_comb begin
    cur_byte = 8'd0;
    for (int k = 0; k < hsfr_pkg::FrameLen; k++) begin
      if (byte_index_q == 3'(k)) cur_byte = frame_q[k];
    end
  end

  assign tl_dec   = tick_left_q - 16'd1;
  assign gap      = in_word_i.edge_time - last_edge_q;   // wraps mod 2^16
  assign sum8     = frame_q[0] + frame_q[1] + frame_q[2] + frame_q[3];
  assign shift_en = (edge_count_q >= hsfr_pkg::FirstBitEdge) &&
                    (edge_count_q < hsfr_pkg::EdgeSat) &&
                    (byte_index_q < 3'(hsfr_pkg::FrameLen));

  always_comb begin
    phase_d       = phase_q;
    tick_left_d   = tick_left_q;
    edge_count_d  = edge_count_q;
    last_edge_d   = last_edge_q;
    bit_in_byte_d = bit_in_byte_q;
    byte_index_d  = byte_index_q;
    frame_d       = frame_q;
    frame_full_d  = frame_full_q;
    line_low_d    = line_low_q;
    status_d      = status_q;
    held_d        = held_q;
    done          = 1'b0;

    if (in_word_i.cmd == hsfr_pkg::CMD_TICK) begin
      tick_left_d = tl_dec;
      unique case (phase_q)
        hsfr_pkg::PH_IDLE: begin
          if (tl_dec == 16'd0) begin
            phase_d     = hsfr_pkg::PH_START;
            tick_left_d = start_ticks_q;
          end
        end
        hsfr_pkg::PH_START: begin
          if (tl_dec == 16'd0) begin
            // open the read window
            line_low_d    = 1'b0;
            edge_count_d  = 6'd0;
            last_edge_d   = 16'd0;
            bit_in_byte_d = 3'd0;
            byte_index_d  = 3'd0;
            frame_full_d  = 1'b0;
            for (int k = 0; k < hsfr_pkg::FrameLen; k++) frame_d[k] = 8'd0;
            phase_d       = hsfr_pkg::PH_READ;
            tick_left_d   = read_ticks_q;
          end else if (tl_dec == start_ticks_q - 16'd1) begin
            line_low_d = 1'b1;
          end
        end
        default: begin
          if (tl_dec == 16'd0) begin
            done = 1'b1;
            if (frame_full_q && sum8 == frame_q[4]) begin
              status_d = 1'b1;
              for (int k = 0; k < hsfr_pkg::HeldLen; k++) held_d[k] = frame_q[k];
            end else begin
              status_d = 1'b0;
            end
            phase_d     = hsfr_pkg::PH_IDLE;
            tick_left_d = idle_ticks_q;
          end
        end
      endcase
    end else if (phase_q == hsfr_pkg::PH_READ) begin
      if (shift_en) begin
        for (int k = 0; k < hsfr_pkg::FrameLen; k++) begin
          if (byte_index_q == 3'(k)) frame_d[k] = {cur_byte[6:0], gap > one_bit_gap_q};
        end
        bit_in_byte_d = bit_in_byte_q + 3'd1;
        if (bit_in_byte_d == 3'd0) begin
          byte_index_d = byte_index_q + 3'd1;
          if (byte_index_d >= 3'(hsfr_pkg::FrameLen)) frame_full_d = 1'b1;
        end
      end
      last_edge_d = in_word_i.edge_time;
      if (edge_count_q < hsfr_pkg::EdgeSat) edge_count_d = edge_count_q + 6'd1;
    end
  end

  always_comb begin
    out_word_d.drive_low  = line_low_d;
    out_word_d.capture_on = (phase_d == hsfr_pkg::PH_READ);
    out_word_d.done_res   = done;
    out_word_d.status     = status_d;
    out_word_d.humid_int  = held_d[0];
    out_word_d.humid_frac = held_d[1];
    out_word_d.temp_int   = held_d[2];
    out_word_d.temp_frac  = held_d[3];
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= hsfr_pkg::PH_IDLE;
      tick_left_q   <= hsfr_pkg::IdleTicksRst;
      edge_count_q  <= 6'd0;
      last_edge_q   <= 16'd0;
      bit_in_byte_q <= 3'd0;
      byte_index_q  <= 3'd0;
      frame_full_q  <= 1'b0;
      line_low_q    <= 1'b0;
      status_q      <= 1'b0;
      for (int k = 0; k < hsfr_pkg::FrameLen; k++) frame_q[k] <= 8'd0;
      for (int k = 0; k < hsfr_pkg::HeldLen; k++) held_q[k] <= 8'd0;
    end else if (in_take) begin
      phase_q       <= phase_d;
      tick_left_q   <= tick_left_d;
      edge_count_q  <= edge_count_d;
      last_edge_q   <= last_edge_d;
      bit_in_byte_q <= bit_in_byte_d;
      byte_index_q  <= byte_index_d;
      frame_full_q  <= frame_full_d;
      line_low_q    <= line_low_d;
      status_q      <= status_d;
      frame_q       <= frame_d;
      held_q        <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      out_word_q <= out_word_d;
    end
  end

endmodule

@@ rtl/hsfr_checker.sv @@
// Port-level checks for the humidity sensor frame reader, bound to the core.
module hsfr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input hsfr_pkg::out_word_t out_word_o
);

  // line is released before the read window opens
  a_low_not_capt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.drive_low && out_word_o.capture_on))
    else $error("drive_low and capture_on both set");

  // closing tick leaves the window shut
  a_done_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.done_res) |-> !out_word_o.capture_on && !out_word_o.drive_low)
    else $error("done word with capture or drive active");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // accepted word always yields a result next cycle
  a_word_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted word produced no result");

  // held result stays while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled result changed");

endmodule

bind humidity_sensor_frame_reader_core hsfr_checker u_hsfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the humidity sensor frame reader core with a cycle-free sensor model.
module testbench;
  import hsfr_pkg::*;

  localparam int CycleLimit = 4_000_000;  // far above the slowest legal run
  localparam int MaxShown   = 10;
  localparam int NumPhases  = 9;

  typedef enum int {
    FR_GOOD,
    FR_BAD_SUM,
    FR_SHORT,
    FR_LONG
  } frame_kind_e;

  // ---------------------------------------------------------------------------
  // DUT ports, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_word_t            in_word_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_word_t           out_word_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [CfgAddrW-1:0] paddr       = '0;
  logic [CfgDataW-1:0] pwdata      = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  humidity_sensor_frame_reader_core u_dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Sensor model state: sequencer, frame shifter, latched result
  // ---------------------------------------------------------------------------
  logic [15:0] reg_val [4];          // idle, start, read, one-bit gap
  phase_e      sq_phase;
  logic [15:0] sq_left;
  logic [5:0]  edge_cnt;
  logic [15:0] last_stamp;
  logic [2:0]  bit_pos;
  logic [2:0]  byte_pos;
  logic [7:0]  frame_buf [FrameLen];
  logic        frame_done;
  logic        line_low;
  logic        capturing;
  logic        good_status;
  logic [7:0]  latched [HeldLen];

  // scoreboard and bookkeeping
  out_word_t   reading_q [$];        // predicted result words, oldest first
  in_word_t    pending_q [$];        // words waiting for the driver
  int          words_queued = 0;
  int          words_in     = 0;
  int          words_out    = 0;
  int          mismatch_cnt = 0;
  int          frames_ok    = 0;
  int          frames_bad   = 0;
  int          settings_cnt = 0;
  int          cycle_cnt    = 0;

  // planner's view of the sequencer, used to shape well-formed traffic
  phase_e      plan_phase;
  logic [15:0] plan_left;

  task automatic reset_model();
    int k;
    reg_val[REG_IDLE_TICKS]  = IdleTicksRst;
    reg_val[REG_START_TICKS] = StartTicksRst;
    reg_val[REG_READ_TICKS]  = ReadTicksRst;
    reg_val[REG_ONE_BIT_GAP] = OneBitGapRst;
    sq_phase    = PH_IDLE;
    sq_left     = IdleTicksRst;
    edge_cnt    = '0;
    last_stamp  = '0;
    bit_pos     = '0;
    byte_pos    = '0;
    frame_done  = 1'b0;
    line_low    = 1'b0;
    capturing   = 1'b0;
    good_status = 1'b0;
    for (k = 0; k < FrameLen; k++) frame_buf[k] = '0;
    for (k = 0; k < HeldLen; k++) latched[k] = '0;
  endtask

  // One accepted word in, one result word out (state after the update).
  function automatic out_word_t sensor_step(in_word_t w);
    out_word_t   seen;
    logic [15:0] gap;
    logic [7:0]  sum;
    logic        closing;
    int          k;
    closing = 1'b0;
    if (w.cmd == CMD_TICK) begin
      // countdown wraps, so a register value of zero means 65536 ticks
      sq_left = sq_left - 16'd1;
      case (sq_phase)
        PH_IDLE: begin
          if (sq_left == 16'd0) begin
            sq_phase = PH_START;
            sq_left  = reg_val[REG_START_TICKS];
          end
        end
        PH_START: begin
          // end of phase wins over the drive-low test
          if (sq_left == 16'd0) begin
            line_low   = 1'b0;
            edge_cnt   = '0;
            last_stamp = '0;
            bit_pos    = '0;
            byte_pos   = '0;
            frame_done = 1'b0;
            for (k = 0; k < FrameLen; k++) frame_buf[k] = '0;
            capturing  = 1'b1;
            sq_phase   = PH_READ;
            sq_left    = reg_val[REG_READ_TICKS];
          end else if (sq_left == reg_val[REG_START_TICKS] - 16'd1) begin
            line_low = 1'b1;
          end
        end
        default: begin
          if (sq_left == 16'd0) begin
            capturing = 1'b0;
            sum = frame_buf[0] + frame_buf[1] + frame_buf[2] + frame_buf[3];
            if (frame_done && sum == frame_buf[4]) begin
              good_status = 1'b1;
              for (k = 0; k < HeldLen; k++) latched[k] = frame_buf[k];
              frames_ok++;
            end else begin
              good_status = 1'b0;
              frames_bad++;
            end
            closing  = 1'b1;
            sq_phase = PH_IDLE;
            sq_left  = reg_val[REG_IDLE_TICKS];
          end
        end
      endcase
    end else if (capturing) begin
      // edges 2..41 carry data; later ones only bump the saturating count
      if (edge_cnt >= FirstBitEdge && edge_cnt < EdgeSat && byte_pos < FrameLen) begin
        gap = w.edge_time - last_stamp;
        frame_buf[byte_pos] = {frame_buf[byte_pos][6:0], gap > reg_val[REG_ONE_BIT_GAP]};
        bit_pos = bit_pos + 3'd1;
        if (bit_pos == 3'd0) begin
          byte_pos = byte_pos + 3'd1;
          if (byte_pos >= FrameLen) frame_done = 1'b1;
        end
      end
      last_stamp = w.edge_time;
      if (edge_cnt < EdgeSat) edge_cnt = edge_cnt + 6'd1;
    end
    seen.drive_low  = line_low;
    seen.capture_on = capturing;
    seen.done_res   = closing;
    seen.status     = good_status;
    seen.humid_int  = latched[0];
    seen.humid_frac = latched[1];
    seen.temp_int   = latched[2];
    seen.temp_frac  = latched[3];
    return seen;
  endfunction

  task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      if (mismatch_cnt < MaxShown)
        $display("mismatch at word %0d, %s: expected %h, got %h", words_out, what, want, got);
      mismatch_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Traffic planning: ticks walk the sequencer, edges form frames
  // ---------------------------------------------------------------------------
  task automatic queue_word(cmd_e c, logic [15:0] stamp);
    in_word_t w;
    w.cmd       = c;
    w.edge_time = stamp;
    pending_q.push_back(w);
    words_queued++;
  endtask

  task automatic queue_tick();
    queue_word(CMD_TICK, 16'($urandom));  // stamp is don't-care on ticks
    plan_left = plan_left - 16'd1;
    if (plan_left == 16'd0) begin
      case (plan_phase)
        PH_IDLE: begin
          plan_phase = PH_START;
          plan_left  = reg_val[REG_START_TICKS];
        end
        PH_START: begin
          plan_phase = PH_READ;
          plan_left  = reg_val[REG_READ_TICKS];
        end
        default: begin
          plan_phase = PH_IDLE;
          plan_left  = reg_val[REG_IDLE_TICKS];
        end
      endcase
    end
  endtask

  // One measurement: run up to the window, send a frame, close the window.
  task automatic queue_measurement(frame_kind_e kind);
    logic [7:0]  frame [FrameLen];
    logic [15:0] stamp;
    logic [15:0] step;
    logic [15:0] thr;
    logic [15:0] room;
    logic        bit_val;
    int          n_edges;
    int          i;
    // stray edges before the window must be ignored
    while (plan_phase != PH_READ) begin
      if ($urandom_range(0, 9) == 0) queue_word(CMD_EDGE, 16'($urandom));
      queue_tick();
    end
    for (i = 0; i < 4; i++) frame[i] = 8'($urandom);
    frame[4] = frame[0] + frame[1] + frame[2] + frame[3];
    if (kind == FR_BAD_SUM) frame[4] = frame[4] ^ 8'($urandom_range(1, 255));
    case (kind)
      FR_SHORT: n_edges = $urandom_range(0, 41);
      FR_LONG:  n_edges = $urandom_range(43, 52);
      default:  n_edges = 42;
    endcase
    thr   = reg_val[REG_ONE_BIT_GAP];
    room  = (thr < 16'd20) ? thr : 16'd20;
    stamp = 16'($urandom);
    for (i = 0; i < n_edges; i++) begin
      // an occasional tick inside a window that stays open
      if (plan_left > 16'd1 && $urandom_range(0, 29) == 0) queue_tick();
      if (i < 2 || i >= 42) begin
        step = 16'($urandom_range(0, 200));
      end else if ($urandom_range(0, 24) == 0) begin
        step = 16'($urandom);
      end else begin
        // gaps hug the threshold; the stamp wraps freely
        bit_val = frame[(i - 2) / 8][7 - (i - 2) % 8];
        if (bit_val) step = thr + 16'd1 + 16'($urandom_range(0, 20));
        else step = thr - 16'($urandom_range(0, room));
      end
      stamp = stamp + step;
      queue_word(CMD_EDGE, stamp);
    end
    while (plan_phase == PH_READ) queue_tick();
  endtask

  // ---------------------------------------------------------------------------
  // APB register access: setup cycle, access cycle, pready always high
  // ---------------------------------------------------------------------------
  task automatic apb_access(logic wr, reg_idx_e idx, logic [15:0] value,
                            output logic [15:0] rd);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata[15:0];
    if (wr) reg_val[idx] = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_regs(logic [15:0] idle_v, logic [15:0] start_v,
                              logic [15:0] read_v, logic [15:0] gap_v);
    logic [15:0] vals [4];
    logic [15:0] rd;
    int          r;
    vals = '{idle_v, start_v, read_v, gap_v};
    for (r = 0; r < 4; r++) apb_access(1'b1, reg_idx_e'(r), vals[r], rd);
    for (r = 0; r < 4; r++) begin
      apb_access(1'b0, reg_idx_e'(r), 16'd0, rd);
      check_field("register readback", reg_val[r], rd);
    end
    settings_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of words with random gaps; a word holds until taken
  // ---------------------------------------------------------------------------
  logic in_taken   = 1'b0;
  int   burst_left = 1;
  int   gap_left   = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (pending_q.size() > 0) begin
        in_word_i  <= pending_q.pop_front();
        in_valid_i <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          // mostly short bursts, now and then a long unbroken stretch
          burst_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 200 : 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: alternating stall and free runs of random length.
  int stall_run = 0;
  bit stall_on  = 1'b0;

  always @(negedge clk_i) begin
    if (stall_run == 0) begin
      stall_on  = ($urandom_range(0, 2) == 0);
      stall_run = stall_on ? $urandom_range(1, 6) : $urandom_range(1, 40);
    end
    stall_run--;
    out_stall_i <= stall_on;
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results first, then predict for the word taken this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (reading_q.size() == 0) begin
          if (mismatch_cnt < MaxShown)
            $display("unexpected result word %0d: %h", words_out, out_word_o);
          mismatch_cnt++;
        end else begin
          want = reading_q.pop_front();
          check_field("drive_low", want.drive_low, out_word_o.drive_low);
          check_field("capture_on", want.capture_on, out_word_o.capture_on);
          check_field("done_res", want.done_res, out_word_o.done_res);
          check_field("status", want.status, out_word_o.status);
          check_field("humid_int", want.humid_int, out_word_o.humid_int);
          check_field("humid_frac", want.humid_frac, out_word_o.humid_frac);
          check_field("temp_int", want.temp_int, out_word_o.temp_int);
          check_field("temp_frac", want.temp_frac, out_word_o.temp_frac);
        end
        words_out++;
      end
      if (in_valid_i && !in_stall_o) begin
        reading_q.push_back(sensor_step(in_word_i));
        words_in++;
      end
      in_taken <= in_valid_i && !in_stall_o;
    end
    cycle_cnt++;
  end

  // Watchdog.
  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence: reset, then phases of register settings and traffic
  // ---------------------------------------------------------------------------
  initial begin
    int          p;
    int          base;
    int          k;
    logic [15:0] gap_v;
    reset_model();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (p = 0; p < NumPhases; p++) begin
      // registers only change with nothing in flight
      case (p)
        0: ;  // reset values
        1: program_regs(16'd1, 16'd2, 16'd1, 16'd90);
        2: program_regs(16'd1, 16'd1, 16'd1, 16'd0);       // window opens at once
        3: program_regs(16'd2, 16'd3, 16'd2, 16'hFFFF);    // every bit reads zero
        NumPhases - 1: program_regs(16'd4, 16'd2, 16'd8, 16'($urandom_range(60, 120)));
        default: begin
          case ($urandom_range(0, 3))
            0:       gap_v = 16'd0;
            1:       gap_v = 16'hFFFF;
            2:       gap_v = 16'($urandom_range(0, 300));
            default: gap_v = 16'($urandom);
          endcase
          program_regs(16'($urandom_range(1, 6)), 16'($urandom_range(1, 5)),
                       16'($urandom_range(1, 4)), gap_v);
        end
      endcase

      plan_phase = sq_phase;
      plan_left  = sq_left;
      base       = words_queued;
      if (p == 0) begin
        // edges at the stamp extremes while idle, then a cut-off and a clean frame
        queue_word(CMD_EDGE, 16'h0000);
        queue_word(CMD_EDGE, 16'hFFFF);
        queue_measurement(FR_SHORT);
        queue_measurement(FR_GOOD);
      end else if (p == NumPhases - 1) begin
        // a wider read window, so ticks land among the edges
        queue_measurement(FR_GOOD);
      end else begin
        while (words_queued - base < 45) begin
          k = $urandom_range(0, 7);
          queue_measurement((k > 3) ? FR_GOOD : frame_kind_e'(k));
        end
      end

      while (words_in != words_queued || reading_q.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
    end

    repeat (8) @(posedge clk_i);
    if (reading_q.size() != 0) begin
      $display("%0d result words never arrived", reading_q.size());
      mismatch_cnt += reading_q.size();
    end
    $display("summary: %0d words in, %0d results out, %0d register settings",
             words_in, words_out, settings_cnt);
    $display("summary: %0d frames accepted, %0d rejected, %0d mismatches",
             frames_ok, frames_bad, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ humidity_sensor_frame_reader_core.f @@
rtl/hsfr_pkg.sv
rtl/humidity_sensor_frame_reader_core.sv
rtl/hsfr_checker.sv
sim/testbench.sv
